// ===== rtl/core/lccs_pkg.sv =====
`default_nettype none
package lccs_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int PASS_WIDTH = 16;
  localparam int GAP_WIDTH = 31;
  localparam int DIV_WIDTH = 40;
  localparam int CNT_WIDTH = 6;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [1:0] op_t;
  localparam op_t OP_FACE = 2'd0;
  localparam op_t OP_TURN = 2'd1;
  localparam op_t OP_PART = 2'd2;
  localparam op_t OP_NEXT = 2'd3;

  typedef logic [1:0] rate_t;
  localparam rate_t RATE_RAPID = 2'd0;
  localparam rate_t RATE_FEED = 2'd1;
  localparam rate_t RATE_RETRACT = 2'd2;

  typedef logic [1:0] stat_t;
  localparam stat_t ST_OK = 2'd0;
  localparam stat_t ST_IDLE = 2'd1;
  localparam stat_t ST_ZERO_STEP = 2'd2;
  localparam stat_t ST_TOO_MANY = 2'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FEED = 3'd0;
  localparam cfg_idx_t CFG_RETRACT = 3'd1;
  localparam cfg_idx_t CFG_CLEAR = 3'd2;
  localparam cfg_idx_t CFG_BACKOFF = 3'd3;
  localparam cfg_idx_t CFG_XDIR = 3'd4;
  localparam cfg_idx_t CFG_ZDIR = 3'd5;

  typedef struct packed {
    logic start;
    logic [COORD_WIDTH-1:0] dividend;
    logic [GAP_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_WIDTH-1:0] quotient;
  } div_rsp_t;

  function automatic coord_t sat(input logic signed [COORD_WIDTH+1:0] v);
    logic signed [COORD_WIDTH+1:0] hi;
    logic signed [COORD_WIDTH+1:0] lo;
    hi = (COORD_WIDTH+2)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - (COORD_WIDTH+2)'(1);
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/lccs_if.sv =====
`default_nettype none
interface lccs_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic signed [31:0] axial_start;
  logic signed [31:0] axial_start_offset;
  logic signed [31:0] axial_end;
  logic signed [31:0] axial_end_offset;
  logic signed [31:0] outer_radius;
  logic signed [31:0] inner_radius;
  logic [30:0] step_len;
  modport source (output valid, opcode, axial_start, axial_start_offset, axial_end,
                  axial_end_offset, outer_radius, inner_radius, step_len, input ready);
  modport sink (input valid, opcode, axial_start, axial_start_offset, axial_end,
                axial_end_offset, outer_radius, inner_radius, step_len, output ready);
endinterface

interface lccs_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] from_x;
  logic signed [31:0] from_z;
  logic signed [31:0] to_x;
  logic signed [31:0] to_z;
  logic [1:0] rate_class;
  logic last_move;
  logic [1:0] status;
  modport source (output valid, from_x, from_z, to_x, to_z, rate_class, last_move, status,
                  input ready);
  modport sink (input valid, from_x, from_z, to_x, to_z, rate_class, last_move, status,
                output ready);
endinterface

interface lccs_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lccs_divider.sv =====
`default_nettype none
module lccs_divider (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire lccs_pkg::div_req_t req,
  output lccs_pkg::div_rsp_t rsp
);
  import lccs_pkg::*;
  logic [DIV_WIDTH-1:0] quo_r, quo_nxt;
  logic [GAP_WIDTH:0] rem_r, rem_nxt;
  logic [GAP_WIDTH-1:0] den_r, den_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [GAP_WIDTH:0] trial;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[GAP_WIDTH-1:0], quo_r[COORD_WIDTH-1]};
    if (req.start) begin
      quo_nxt = DIV_WIDTH'(req.dividend);
      rem_nxt = '0; den_nxt = req.divisor;
      cnt_nxt = CNT_WIDTH'(COORD_WIDTH); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = DIV_WIDTH'({quo_r[COORD_WIDTH-2:0], 1'b1});
      end else begin
        rem_nxt = trial;
        quo_nxt = DIV_WIDTH'({quo_r[COORD_WIDTH-2:0], 1'b0});
      end
      cnt_nxt = cnt_r - CNT_WIDTH'(1);
      if (cnt_r == CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (rem_nxt != '0) quo_nxt = quo_nxt + DIV_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt; rem_r <= rem_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/lathe_canned_cycle_sequencer.sv =====
// Lathe canned-cycle sequencer. A start word (facing, turning, parting) captures geometry and
// computes ceil(distance/step) with a shared restoring divider, one quotient bit per cycle:
// a start passes from capture through the distance and divider-start states to the divide
// (skipped for a zero step) and its status word is registered when it is done; a next-move
// word passes through a move state and an output state. One word is in flight at a time; the
// result sits in an output register until taken. Configuration words are taken at any time.
`default_nettype none
module lathe_canned_cycle_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  lccs_in_if.sink   in_ch,
  lccs_out_if.source out_ch,
  lccs_cfg_if.sink  cfg_ch
);
  import lccs_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_FIN, S_MOVE, S_OUT} state_t;
  typedef enum logic [1:0] {K_IDLE, K_FACE, K_TURN, K_PART} kind_t;
  typedef logic signed [COORD_WIDTH+1:0] wide_t;

  state_t state_r;
  kind_t kind_r, nkind_r;
  logic [3:0] phase_r;
  logic [PASS_WIDTH-1:0] passes_r;
  coord_t cur_r, delta_r;
  coord_t g_r [6];
  coord_t zs_r, ze_r, outer_r, inner_r;
  logic [GAP_WIDTH-1:0] step_r;
  logic [COORD_WIDTH-1:0] dist_r;
  logic [GAP_WIDTH-1:0] feed_r, retr_r, clr_r, back_r;
  logic xdir_r, zdir_r;
  coord_t ofx_r, ofz_r, otx_r, otz_r;
  rate_t orate_r;
  logic olast_r, ovalid_r;
  stat_t ostat_r;
  div_req_t dreq;
  div_rsp_t drsp;
  wide_t a_w, b_w, c_w, d_w, bz_w;
  coord_t sa, sb, sc;
  logic [PASS_WIDTH-1:0] pleft;
  logic lastp;

  lccs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.from_x = ofx_r;
  assign out_ch.from_z = ofz_r;
  assign out_ch.to_x = otx_r;
  assign out_ch.to_z = otz_r;
  assign out_ch.rate_class = orate_r;
  assign out_ch.last_move = olast_r;
  assign out_ch.status = ostat_r;

  always_comb begin
    dreq.start = (state_r == S_PREP) && (step_r != '0);
    dreq.dividend = dist_r;
    dreq.divisor = step_r;
    a_w = wide_t'(outer_r) + wide_t'({1'b0, feed_r});
    b_w = a_w + wide_t'({1'b0, retr_r});
    c_w = b_w + wide_t'({1'b0, clr_r});
    sa = sat(a_w); sb = sat(b_w); sc = sat(c_w);
    if (kind_r == K_FACE) d_w = wide_t'(ze_r) - wide_t'(zs_r);
    else d_w = wide_t'(outer_r) - wide_t'(inner_r);
    bz_w = zdir_r ? wide_t'(zs_r) + wide_t'({1'b0, back_r})
                  : wide_t'(zs_r) - wide_t'({1'b0, back_r});
    pleft = (passes_r != '0) ? passes_r - PASS_WIDTH'(1) : passes_r;
    lastp = (pleft == '0);
  end

  task automatic emit(input coord_t fx, input coord_t fz, input coord_t tx, input coord_t tz,
                      input rate_t rt, input logic lst);
    ofx_r <= fx; ofz_r <= fz; otx_r <= tx; otz_r <= tz;
    orate_r <= rt; olast_r <= lst; ostat_r <= ST_OK; ovalid_r <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; kind_r <= K_IDLE; nkind_r <= K_IDLE; phase_r <= '0;
      passes_r <= '0; cur_r <= '0; delta_r <= '0; ovalid_r <= 1'b0;
      feed_r <= '0; retr_r <= '0; clr_r <= '0; back_r <= '0;
      xdir_r <= 1'b1; zdir_r <= 1'b1;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_FEED: feed_r <= cfg_ch.data[GAP_WIDTH-1:0];
          CFG_RETRACT: retr_r <= cfg_ch.data[GAP_WIDTH-1:0];
          CFG_CLEAR: clr_r <= cfg_ch.data[GAP_WIDTH-1:0];
          CFG_BACKOFF: back_r <= cfg_ch.data[GAP_WIDTH-1:0];
          CFG_XDIR: xdir_r <= cfg_ch.data[0];
          CFG_ZDIR: zdir_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            zs_r <= sat(wide_t'(in_ch.axial_start) + wide_t'(in_ch.axial_start_offset));
            ze_r <= sat(wide_t'(in_ch.axial_end) + wide_t'(in_ch.axial_end_offset));
            outer_r <= in_ch.outer_radius;
            inner_r <= in_ch.inner_radius;
            step_r <= in_ch.step_len;
            if (in_ch.opcode == OP_NEXT) state_r <= S_MOVE;
            else begin
              nkind_r <= kind_t'(in_ch.opcode + 2'd1);
              kind_r <= (in_ch.opcode == OP_FACE) ? K_FACE : K_TURN;
              state_r <= S_FIN;
              phase_r <= 4'd15;
            end
          end
        end
        S_FIN: begin
          kind_r <= K_IDLE;
          phase_r <= '0;
          dist_r <= COORD_WIDTH'(d_w < 0 ? -d_w : d_w);
          state_r <= S_PREP;
        end
        S_PREP: begin
          if (step_r == '0) begin
            ofx_r <= '0; ofz_r <= '0; otx_r <= '0; otz_r <= '0; orate_r <= RATE_RAPID;
            olast_r <= 1'b0; ostat_r <= ST_ZERO_STEP; ovalid_r <= 1'b1;
            state_r <= S_IDLE;
          end else state_r <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            ofx_r <= '0; ofz_r <= '0; otx_r <= '0; otz_r <= '0; orate_r <= RATE_RAPID;
            olast_r <= 1'b0; ovalid_r <= 1'b1;
            state_r <= S_IDLE;
            if (drsp.quotient > DIV_WIDTH'({PASS_WIDTH{1'b1}})) ostat_r <= ST_TOO_MANY;
            else begin
              ostat_r <= ST_OK;
              passes_r <= (drsp.quotient == '0) ? PASS_WIDTH'(1)
                                                : PASS_WIDTH'(drsp.quotient);
              g_r[2] <= sc; g_r[3] <= sb; g_r[4] <= sa; g_r[5] <= inner_r;
              kind_r <= nkind_r;
              if (nkind_r == K_FACE) begin
                g_r[0] <= sat(bz_w); g_r[1] <= ze_r; cur_r <= zs_r;
                delta_r <= zdir_r ? -coord_t'({1'b0, step_r}) : coord_t'({1'b0, step_r});
              end else begin
                g_r[0] <= zs_r; g_r[1] <= (nkind_r == K_TURN) ? ze_r : zs_r;
                cur_r <= outer_r;
                delta_r <= xdir_r ? -coord_t'({1'b0, step_r}) : coord_t'({1'b0, step_r});
              end
            end
          end
        end
        S_MOVE: begin
          state_r <= S_OUT;
          if ((kind_r == K_FACE && phase_r == 4'd1) ||
              (kind_r != K_FACE && kind_r != K_IDLE && phase_r == 4'd2))
            cur_r <= (passes_r > PASS_WIDTH'(1))
                     ? sat(wide_t'(cur_r) + wide_t'(delta_r))
                     : ((kind_r == K_FACE) ? g_r[1] : g_r[5]);
        end
        S_OUT: begin
          state_r <= S_IDLE;
          case (kind_r)
            K_FACE: begin
              case (phase_r)
                4'd0: begin emit(g_r[2], g_r[0], g_r[3], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd1; end
                4'd1: begin emit(g_r[3], g_r[0], g_r[3], cur_r, RATE_RAPID, 1'b0);
                  phase_r <= 4'd2; end
                4'd2: begin emit(g_r[3], cur_r, g_r[4], cur_r, RATE_RAPID, 1'b0);
                  phase_r <= 4'd3; end
                4'd3: begin emit(g_r[4], cur_r, g_r[5], cur_r, RATE_FEED, 1'b0);
                  phase_r <= 4'd4; end
                4'd4: begin emit(g_r[5], cur_r, g_r[5], g_r[0], RATE_RETRACT, 1'b0);
                  phase_r <= 4'd5; end
                4'd5: begin emit(g_r[5], g_r[0], g_r[3], g_r[0], RATE_RETRACT, 1'b0);
                  passes_r <= pleft; phase_r <= lastp ? 4'd6 : 4'd1; end
                default: begin emit(g_r[3], g_r[0], g_r[2], g_r[0], RATE_RAPID, 1'b1);
                  kind_r <= K_IDLE; phase_r <= '0; end
              endcase
            end
            K_TURN: begin
              case (phase_r)
                4'd0: begin emit(g_r[2], g_r[0], g_r[3], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd1; end
                4'd1: begin emit(g_r[3], g_r[0], g_r[4], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd2; end
                4'd2: begin emit(g_r[4], g_r[0], cur_r, g_r[0], RATE_FEED, 1'b0);
                  phase_r <= 4'd3; end
                4'd3: begin emit(cur_r, g_r[0], cur_r, g_r[1], RATE_FEED, 1'b0);
                  phase_r <= 4'd4; end
                4'd4: begin emit(cur_r, g_r[1], g_r[3], g_r[1], RATE_RETRACT, 1'b0);
                  passes_r <= pleft; phase_r <= lastp ? 4'd6 : 4'd5; end
                4'd5: begin emit(g_r[3], g_r[1], g_r[3], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd1; end
                default: begin emit(g_r[3], g_r[1], g_r[2], g_r[1], RATE_RAPID, 1'b1);
                  kind_r <= K_IDLE; phase_r <= '0; end
              endcase
            end
            K_PART: begin
              case (phase_r)
                4'd0: begin emit(g_r[2], g_r[0], g_r[3], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd1; end
                4'd1: begin emit(g_r[3], g_r[0], g_r[4], g_r[0], RATE_RAPID, 1'b0);
                  phase_r <= 4'd2; end
                4'd2: begin emit(g_r[4], g_r[0], cur_r, g_r[0], RATE_FEED, 1'b0);
                  phase_r <= 4'd3; end
                4'd3: begin emit(cur_r, g_r[0], g_r[3], g_r[0], RATE_RETRACT, 1'b0);
                  passes_r <= pleft; phase_r <= lastp ? 4'd4 : 4'd1; end
                default: begin emit(g_r[3], g_r[0], g_r[2], g_r[0], RATE_RAPID, 1'b1);
                  kind_r <= K_IDLE; phase_r <= '0; end
              endcase
            end
            default: begin
              ofx_r <= '0; ofz_r <= '0; otx_r <= '0; otz_r <= '0; orate_r <= RATE_RAPID;
              olast_r <= 1'b0; ostat_r <= ST_IDLE; ovalid_r <= 1'b1;
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/lccs_checker.sv =====
`default_nettype none
module lccs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] rate_class,
  input wire logic last_move,
  input wire logic [1:0] status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_rate_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rate_class != 2'd3)
    else $error("bad rate class");
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_move |-> status == 2'd0 && rate_class == 2'd0)
    else $error("last segment with error status");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");
endmodule

bind lathe_canned_cycle_sequencer lccs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .rate_class(out_ch.rate_class),
  .last_move(out_ch.last_move), .status(out_ch.status));
`default_nettype wire

// ===== dv/tb_lathe_canned_cycle_sequencer.sv =====
`timescale 1ns / 100ps
module tb_lathe_canned_cycle_sequencer;
  import lccs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 60;
  localparam int RANDOM_WORDS = 1200;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  typedef enum logic [1:0] {K_IDLE, K_FACE, K_TURN, K_PART} kind_e;

  typedef struct {
    op_t opcode;
    longint z0, z0_off, z1, z1_off, outer, inner;
    longint step;
    bit typed;
    stat_t typed_status;
  } move_word_t;

  typedef struct {
    coord_t from_x, from_z, to_x, to_z;
    rate_t rate;
    logic last;
    stat_t status;
  } segment_t;

  logic clk;
  logic rst_n;
  int cycles;
  int misses;
  int words_sent;
  int segs_seen;
  bit calm;
  int ready_hold;

  lccs_in_if in_if (clk);
  lccs_out_if out_if (clk);
  lccs_cfg_if cfg_if (clk);

  lathe_canned_cycle_sequencer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  segment_t seg_q[$];
  move_word_t directed[$];

  longint gap_feed, gap_retract, gap_clear, gap_backoff;
  bit x_pos, z_pos;
  kind_e cut_kind;
  int cut_phase;
  int unsigned passes_to_go;
  longint tool_pos;
  longint pass_delta;
  longint geom[6];

  function automatic longint clamp(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic segment_t seg(longint fx, longint fz, longint tx, longint tz,
                                   rate_t r, logic l, stat_t s);
    segment_t g;
    g.from_x = coord_t'(fx);
    g.from_z = coord_t'(fz);
    g.to_x = coord_t'(tx);
    g.to_z = coord_t'(tz);
    g.rate = r;
    g.last = l;
    g.status = s;
    return g;
  endfunction

  function automatic void step_pass(longint final_pos);
    if (passes_to_go > 1) tool_pos = clamp(tool_pos + pass_delta);
    else tool_pos = final_pos;
  endfunction

  function automatic bit finish_pass();
    if (passes_to_go > 0) passes_to_go--;
    return passes_to_go == 0;
  endfunction

  function automatic void clear_gen_state();
    gap_feed = 0; gap_retract = 0; gap_clear = 0; gap_backoff = 0;
    x_pos = 1; z_pos = 1;
    cut_kind = K_IDLE; cut_phase = 0; passes_to_go = 0; tool_pos = 0; pass_delta = 0;
    foreach (geom[i]) geom[i] = 0;
  endfunction

  function automatic segment_t start_cycle(move_word_t w);
    kind_e k;
    longint zs, ze, a, b, c, d, sgn;
    longint unsigned span, n;
    k = kind_e'(w.opcode + 1);
    zs = clamp(w.z0 + w.z0_off);
    ze = clamp(w.z1 + w.z1_off);
    a = w.outer + gap_feed;
    b = a + gap_retract;
    c = b + gap_clear;
    cut_kind = K_IDLE;
    cut_phase = 0;
    if (w.step == 0) return seg(0, 0, 0, 0, RATE_RAPID, 0, ST_ZERO_STEP);
    d = (k == K_FACE) ? ze - zs : w.outer - w.inner;
    span = d < 0 ? -d : d;
    n = (span + w.step - 1) / w.step;
    if (n == 0) n = 1;
    if (n > (64'd1 << PASS_WIDTH) - 1) return seg(0, 0, 0, 0, RATE_RAPID, 0, ST_TOO_MANY);
    geom[2] = clamp(c);
    geom[3] = clamp(b);
    geom[4] = clamp(a);
    geom[5] = w.inner;
    if (k == K_FACE) begin
      sgn = z_pos ? -1 : 1;
      geom[0] = clamp(zs - sgn * gap_backoff);
      geom[1] = ze;
      tool_pos = zs;
    end else begin
      sgn = x_pos ? -1 : 1;
      geom[0] = zs;
      geom[1] = (k == K_TURN) ? ze : zs;
      tool_pos = w.outer;
    end
    pass_delta = sgn * w.step;
    passes_to_go = 32'(n);
    cut_kind = k;
    return seg(0, 0, 0, 0, RATE_RAPID, 0, ST_OK);
  endfunction

  function automatic segment_t next_move();
    longint z0, z1, cx, rx, fx, ix;
    segment_t g;
    z0 = geom[0]; z1 = geom[1]; cx = geom[2]; rx = geom[3]; fx = geom[4]; ix = geom[5];
    case (cut_kind)
      K_FACE: begin
        case (cut_phase)
          0: begin g = seg(cx, z0, rx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 1; end
          1: begin
            step_pass(z1);
            g = seg(rx, z0, rx, tool_pos, RATE_RAPID, 0, ST_OK); cut_phase = 2;
          end
          2: begin g = seg(rx, tool_pos, fx, tool_pos, RATE_RAPID, 0, ST_OK); cut_phase = 3; end
          3: begin g = seg(fx, tool_pos, ix, tool_pos, RATE_FEED, 0, ST_OK); cut_phase = 4; end
          4: begin g = seg(ix, tool_pos, ix, z0, RATE_RETRACT, 0, ST_OK); cut_phase = 5; end
          5: begin
            g = seg(ix, z0, rx, z0, RATE_RETRACT, 0, ST_OK);
            cut_phase = finish_pass() ? 6 : 1;
          end
          default: begin
            g = seg(rx, z0, cx, z0, RATE_RAPID, 1, ST_OK); cut_kind = K_IDLE; cut_phase = 0;
          end
        endcase
      end
      K_TURN: begin
        case (cut_phase)
          0: begin g = seg(cx, z0, rx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 1; end
          1: begin g = seg(rx, z0, fx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 2; end
          2: begin
            step_pass(ix);
            g = seg(fx, z0, tool_pos, z0, RATE_FEED, 0, ST_OK); cut_phase = 3;
          end
          3: begin g = seg(tool_pos, z0, tool_pos, z1, RATE_FEED, 0, ST_OK); cut_phase = 4; end
          4: begin
            g = seg(tool_pos, z1, rx, z1, RATE_RETRACT, 0, ST_OK);
            cut_phase = finish_pass() ? 6 : 5;
          end
          5: begin g = seg(rx, z1, rx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 1; end
          default: begin
            g = seg(rx, z1, cx, z1, RATE_RAPID, 1, ST_OK); cut_kind = K_IDLE; cut_phase = 0;
          end
        endcase
      end
      K_PART: begin
        case (cut_phase)
          0: begin g = seg(cx, z0, rx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 1; end
          1: begin g = seg(rx, z0, fx, z0, RATE_RAPID, 0, ST_OK); cut_phase = 2; end
          2: begin
            step_pass(ix);
            g = seg(fx, z0, tool_pos, z0, RATE_FEED, 0, ST_OK); cut_phase = 3;
          end
          3: begin
            g = seg(tool_pos, z0, rx, z0, RATE_RETRACT, 0, ST_OK);
            cut_phase = finish_pass() ? 4 : 1;
          end
          default: begin
            g = seg(rx, z0, cx, z0, RATE_RAPID, 1, ST_OK); cut_kind = K_IDLE; cut_phase = 0;
          end
        endcase
      end
      default: g = seg(0, 0, 0, 0, RATE_RAPID, 0, ST_IDLE);
    endcase
    return g;
  endfunction

  function automatic segment_t predict_segment(move_word_t w);
    if (w.opcode == OP_NEXT) return next_move();
    return start_cycle(w);
  endfunction

  task automatic report_miss(string field, longint got, longint want);
    misses++;
    if (misses <= 30)
      $display("mismatch on %s at segment %0d: got %0d, want %0d", field, segs_seen, got, want);
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_if.ready <= rst_n;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
      ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    segment_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (seg_q.size() == 0) begin
        report_miss("unexpected word", 1, 0);
      end else begin
        want = seg_q.pop_front();
        if (out_if.from_x !== want.from_x) report_miss("from_x", out_if.from_x, want.from_x);
        if (out_if.from_z !== want.from_z) report_miss("from_z", out_if.from_z, want.from_z);
        if (out_if.to_x !== want.to_x) report_miss("to_x", out_if.to_x, want.to_x);
        if (out_if.to_z !== want.to_z) report_miss("to_z", out_if.to_z, want.to_z);
        if (out_if.rate_class !== want.rate) report_miss("rate_class", out_if.rate_class, want.rate);
        if (out_if.last_move !== want.last) report_miss("last_move", out_if.last_move, want.last);
        if (out_if.status !== want.status) report_miss("status", out_if.status, want.status);
      end
      segs_seen++;
    end
  end

  task automatic hold_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_FEED: gap_feed = value[30:0];
      CFG_RETRACT: gap_retract = value[30:0];
      CFG_CLEAR: gap_clear = value[30:0];
      CFG_BACKOFF: gap_backoff = value[30:0];
      CFG_XDIR: x_pos = value[0];
      CFG_ZDIR: z_pos = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (seg_q.size() != 0) @(posedge clk);
    hold_cycles(SETTLE);
  endtask

  task automatic load_setting(logic [31:0] fg, logic [31:0] rg, logic [31:0] cg,
                              logic [31:0] bo, logic xd, logic zd);
    drain();
    write_reg(CFG_FEED, fg);
    write_reg(CFG_RETRACT, rg);
    write_reg(CFG_CLEAR, cg);
    write_reg(CFG_BACKOFF, bo);
    write_reg(CFG_XDIR, {31'd0, xd});
    write_reg(CFG_ZDIR, {31'd0, zd});
    cfg_if.valid <= 0;
  endtask

  task automatic send_word(move_word_t w);
    segment_t want;
    int gap;
    in_if.valid <= 1;
    in_if.opcode <= w.opcode;
    in_if.axial_start <= w.z0[31:0];
    in_if.axial_start_offset <= w.z0_off[31:0];
    in_if.axial_end <= w.z1[31:0];
    in_if.axial_end_offset <= w.z1_off[31:0];
    in_if.outer_radius <= w.outer[31:0];
    in_if.inner_radius <= w.inner[31:0];
    in_if.step_len <= w.step[30:0];
    do @(posedge clk); while (!in_if.ready);
    want = predict_segment(w);
    if (w.typed) begin
      if (want.status !== w.typed_status) report_miss("typed status", want.status, w.typed_status);
      want = seg(0, 0, 0, 0, RATE_RAPID, 0, w.typed_status);
    end
    seg_q.push_back(want);
    words_sent++;
    if (calm) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 50);
    else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      in_if.valid <= 0;
      hold_cycles(gap);
    end
  endtask

  function automatic move_word_t mk(op_t op, longint z0, longint z0o, longint z1, longint z1o,
                                    longint o, longint i, longint st, bit typed, stat_t ts);
    move_word_t w;
    w.opcode = op; w.z0 = z0; w.z0_off = z0o; w.z1 = z1; w.z1_off = z1o;
    w.outer = o; w.inner = i; w.step = st; w.typed = typed; w.typed_status = ts;
    return w;
  endfunction

  function automatic move_word_t next_word();
    return mk(OP_NEXT, $signed($urandom), $signed($urandom), $signed($urandom),
              $signed($urandom), $signed($urandom), $signed($urandom), $urandom, 0, ST_OK);
  endfunction

  function automatic longint any32();
    return longint'($signed($urandom));
  endfunction

  function automatic move_word_t rand_start();
    move_word_t w;
    longint st;
    bit wild;
    w = next_word();
    w.opcode = op_t'($urandom_range(0, 2));
    wild = ($urandom_range(0, 9) == 0);
    st = $urandom_range(1, 5000);
    if (wild) begin
      w.step = ($urandom_range(0, 1) != 0) ? longint'($urandom & 32'h7fffffff) : st;
    end else begin
      w.step = st;
      w.z0 = any32() >>> $urandom_range(0, 31);
      w.z0_off = $signed($urandom_range(0, 2000)) - 1000;
      w.z1 = w.z0 + (($urandom_range(0, 1) != 0) ? 1 : -1) *
             longint'($urandom_range(0, st * 8));
      w.z1_off = $signed($urandom_range(0, 2000)) - 1000;
      w.outer = any32() >>> $urandom_range(0, 31);
      w.inner = w.outer + (($urandom_range(0, 1) != 0) ? 1 : -1) *
                longint'($urandom_range(0, st * 8));
      w.z1 = clamp(w.z1);
      w.inner = clamp(w.inner);
    end
    if ($urandom_range(0, 29) == 0) w.step = 0;
    return w;
  endfunction

  task automatic random_run(int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 11) == 0) begin
        send_word(next_word());
        sent++;
      end else begin
        send_word(rand_start());
        sent++;
        while (cut_kind != K_IDLE && $urandom_range(0, 79) != 0) begin
          send_word(next_word());
          sent++;
        end
      end
    end
    in_if.valid <= 0;
    calm = 0;
  endtask

  initial begin
    move_word_t w;
    rst_n = 0;
    cycles = 0; misses = 0; words_sent = 0; segs_seen = 0; calm = 0; ready_hold = 0;
    in_if.valid = 0; in_if.opcode = OP_NEXT; in_if.axial_start = 0;
    in_if.axial_start_offset = 0; in_if.axial_end = 0; in_if.axial_end_offset = 0;
    in_if.outer_radius = 0; in_if.inner_radius = 0; in_if.step_len = 0;
    cfg_if.valid = 0; cfg_if.index = CFG_FEED; cfg_if.data = 0;
    out_if.ready = 0;
    clear_gen_state();

    directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 1, ST_IDLE));
    directed.push_back(mk(OP_FACE, 100, 0, 900, 0, 500, 0, 0, 1, ST_ZERO_STEP));
    directed.push_back(mk(OP_TURN, 0, 0, 0, 0, CMAX, CMIN, 1, 1, ST_TOO_MANY));
    directed.push_back(mk(OP_PART, 300, 7, 0, 0, 4000, 4000, 1, 1, ST_OK));
    repeat (5) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk(OP_NEXT, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 32'h7fffffff, 1, ST_IDLE));
    directed.push_back(mk(OP_FACE, 5000, 0, 1000, 0, 8000, 200, 7000, 1, ST_OK));
    repeat (7) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk(OP_FACE, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 32'h7fffffff, 1, ST_OK));
    repeat (2) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk(OP_TURN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, 32'h7fffffff, 1, ST_OK));
    repeat (4) directed.push_back(mk(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i]);
    in_if.valid <= 0;

    load_setting(100, 250, 1000, 50, 0, 0);
    random_run(RANDOM_WORDS / 4);
    load_setting(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1);
    random_run(RANDOM_WORDS / 4);
    load_setting(0, 0, 0, 0, 0, 1);
    random_run(RANDOM_WORDS / 4);
    load_setting($urandom_range(0, 100000), $urandom_range(0, 100000),
                 $urandom & 32'h7fffffff, $urandom_range(0, 100000), 1, 0);
    random_run(RANDOM_WORDS / 4);
    in_if.valid <= 0;

    drain();
    $display("run covered %0d move words and %0d segments over four register settings",
             words_sent, segs_seen);
    $display("directed extremes, zero step, pass overflow, abandon and idle moves included");
    if (misses == 0 && seg_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
